/* rtl/cstoi_pkg.sv */
package cstoi_pkg;

   localparam int PosW   = 32;
   localparam int RadW   = 31;
   localparam int DiffW  = 33;
   localparam int RsumW  = 32;
   localparam int SqW    = 66;
   localparam int AW     = 66;
   localparam int HW     = 67;
   localparam int CW     = 66;
   localparam int SplitW = 34;
   localparam int DiscW  = 134;
   localparam int RootW  = 67;
   localparam int NumW   = 68;
   localparam int FracW  = 16;
   localparam int TimeW  = 32;
   localparam int RemW   = 66;
   localparam int ReqW   = 320;
   localparam int RspW   = 40;

   typedef struct packed {
      logic [RadW-1:0] second_radius;
      logic [PosW-1:0] second_vel_y;
      logic [PosW-1:0] second_vel_x;
      logic [PosW-1:0] second_pos_y;
      logic [PosW-1:0] second_pos_x;
      logic [RadW-1:0] first_radius;
      logic [PosW-1:0] first_vel_y;
      logic [PosW-1:0] first_vel_x;
      logic [PosW-1:0] first_pos_y;
      logic [PosW-1:0] first_pos_x;
   } pair_type;

   typedef struct packed {
      logic [AW-1:0] a;
      logic [HW-1:0] hmag;
      logic          hle0;
      logic          cge0;
      logic          cle0;
      logic          ok;
   } side_type;

   typedef struct packed {
      logic             late_root;
      logic [TimeW-1:0] contact_time;
      logic             hit;
   } res_type;

endpackage

/* rtl/cstoi_front.sv */
module cstoi_front
   import cstoi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  pair_type         in_pair,
   output logic             out_valid,
   output logic [DiscW-1:0] out_disc,
   output side_type         out_side
);

   // stage 1: relative position, velocity, radius sum
   logic                    v1_ff;
   logic signed [DiffW-1:0] px_ff, py_ff, vx_ff, vy_ff;
   logic [RsumW-1:0]        rs_ff;
   // stage 2: squares and dot products
   logic                    v2_ff;
   logic signed [SqW-1:0]   vxx_ff, vyy_ff, pxx_ff, pyy_ff, pxvx_ff, pyvy_ff;
   logic [2*RsumW-1:0]      rr_ff;
   // stage 3: a, h, c
   logic                    v3_ff;
   logic [AW-1:0]           a_ff;
   logic signed [HW-1:0]    h_ff, c_ff;
   // stage 4: magnitudes and signs
   logic                    v4_ff;
   side_type                s4_ff;
   logic [CW-1:0]           cmag_ff;
   logic                    cneg_ff;
   // stage 5: partial products
   logic                    v5_ff;
   side_type                s5_ff;
   logic                    cneg5_ff;
   logic [2*SplitW-1:0]     hll_ff, all_ff;
   logic [SplitW+HW-2*SplitW-1+SplitW:0] hlh_ff;
   logic [2*(HW-SplitW)-1:0] hhh_ff;
   logic [AW-1:0]           alh_ff, ahl_ff;
   logic [2*(AW-SplitW)-1:0] ahh_ff;
   // stage 6: full square of h and full product of a and c
   logic                    v6_ff;
   side_type                s6_ff;
   logic                    cneg6_ff;
   logic [DiscW-1:0]        h2_ff, ac_ff;
   // stage 7: discriminant
   logic                    v7_ff;
   side_type                s7_ff;
   logic [DiscW-1:0]        d_ff;

   logic signed [HW-1:0]    h_in, c_in;
   logic [AW-1:0]           a_in;
   logic [HW-1:0]           hmag_in, cabs_in;
   side_type                s4_in, s7_in;
   logic [DiscW-1:0]        h2_in, ac_in, dsum_in;
   logic [DiscW:0]          ddif_in;

   always_comb begin
      a_in = {1'b0, vxx_ff[SqW-2:0]} + {1'b0, vyy_ff[SqW-2:0]};
      h_in = {pxvx_ff[SqW-1], pxvx_ff} + {pyvy_ff[SqW-1], pyvy_ff};
      c_in = $signed({2'b0, pxx_ff[SqW-2:0]} + {2'b0, pyy_ff[SqW-2:0]}
                     - {3'b0, rr_ff});
   end

   always_comb begin
      hmag_in    = h_ff[HW-1] ? HW'(-h_ff) : h_ff;
      cabs_in    = c_ff[HW-1] ? HW'(-c_ff) : c_ff;
      s4_in.a    = a_ff;
      s4_in.hmag = hmag_in;
      s4_in.hle0 = h_ff[HW-1] || (h_ff == '0);
      s4_in.cge0 = !c_ff[HW-1];
      s4_in.cle0 = c_ff[HW-1] || (c_ff == '0);
      s4_in.ok   = 1'b0;
   end

   always_comb begin
      h2_in = ({{(DiscW-2*(HW-SplitW)){1'b0}}, hhh_ff} << (2*SplitW))
            + (DiscW'(hlh_ff) << (SplitW+1))
            + DiscW'(hll_ff);
      ac_in = ({{(DiscW-2*(AW-SplitW)){1'b0}}, ahh_ff} << (2*SplitW))
            + ((DiscW'(alh_ff) + DiscW'(ahl_ff)) << SplitW)
            + DiscW'(all_ff);
   end

   always_comb begin
      dsum_in  = h2_ff + ac_ff;
      ddif_in  = {1'b0, h2_ff} - {1'b0, ac_ff};
      s7_in    = s6_ff;
      // a negative discriminant or a standing pair gives no hit
      s7_in.ok = (cneg6_ff || !ddif_in[DiscW]) && (s6_ff.a != '0)
                 && (s6_ff.hle0 || s6_ff.cle0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; v7_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; v6_ff <= v5_ff; v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= $signed({in_pair.second_pos_x[PosW-1], in_pair.second_pos_x}
                        - {in_pair.first_pos_x[PosW-1], in_pair.first_pos_x});
         py_ff <= $signed({in_pair.second_pos_y[PosW-1], in_pair.second_pos_y}
                        - {in_pair.first_pos_y[PosW-1], in_pair.first_pos_y});
         vx_ff <= $signed({in_pair.second_vel_x[PosW-1], in_pair.second_vel_x}
                        - {in_pair.first_vel_x[PosW-1], in_pair.first_vel_x});
         vy_ff <= $signed({in_pair.second_vel_y[PosW-1], in_pair.second_vel_y}
                        - {in_pair.first_vel_y[PosW-1], in_pair.first_vel_y});
         rs_ff <= {1'b0, in_pair.first_radius} + {1'b0, in_pair.second_radius};

         vxx_ff  <= vx_ff * vx_ff;
         vyy_ff  <= vy_ff * vy_ff;
         pxx_ff  <= px_ff * px_ff;
         pyy_ff  <= py_ff * py_ff;
         pxvx_ff <= px_ff * vx_ff;
         pyvy_ff <= py_ff * vy_ff;
         rr_ff   <= rs_ff * rs_ff;

         a_ff <= a_in;
         h_ff <= h_in;
         c_ff <= c_in;

         s4_ff   <= s4_in;
         cmag_ff <= cabs_in[CW-1:0];
         cneg_ff <= c_ff[HW-1];

         s5_ff    <= s4_ff;
         cneg5_ff <= cneg_ff;
         hll_ff   <= s4_ff.hmag[SplitW-1:0] * s4_ff.hmag[SplitW-1:0];
         hlh_ff   <= s4_ff.hmag[SplitW-1:0] * s4_ff.hmag[HW-1:SplitW];
         hhh_ff   <= s4_ff.hmag[HW-1:SplitW] * s4_ff.hmag[HW-1:SplitW];
         all_ff   <= s4_ff.a[SplitW-1:0] * cmag_ff[SplitW-1:0];
         alh_ff   <= s4_ff.a[SplitW-1:0] * cmag_ff[CW-1:SplitW];
         ahl_ff   <= s4_ff.a[AW-1:SplitW] * cmag_ff[SplitW-1:0];
         ahh_ff   <= s4_ff.a[AW-1:SplitW] * cmag_ff[CW-1:SplitW];

         s6_ff    <= s5_ff;
         cneg6_ff <= cneg5_ff;
         h2_ff    <= h2_in;
         ac_ff    <= ac_in;

         s7_ff <= s7_in;
         d_ff  <= cneg6_ff ? dsum_in : ddif_in[DiscW-1:0];
      end
   end

   assign out_valid = v7_ff;
   assign out_disc  = d_ff;
   assign out_side  = s7_ff;

endmodule

/* rtl/cstoi_sqrt.sv */
module cstoi_sqrt
   import cstoi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [DiscW-1:0] in_disc,
   input  side_type         in_side,
   output logic             out_valid,
   output logic [RootW-1:0] out_root,
   output side_type         out_side
);

   // one root bit per stage, most significant first
   logic             v_ff [RootW];
   logic [DiscW-1:0] x_ff [RootW];
   logic [RootW-1:0] q_ff [RootW];
   side_type         s_ff [RootW];

   for (genvar i = 0; i < RootW; i++) begin : g_bit
      localparam int K = RootW - 1 - i;
      logic             v_prev;
      logic [DiscW-1:0] x_prev, trial;
      logic [RootW-1:0] q_prev;
      side_type         s_prev;

      if (i == 0) begin : g_first
         assign v_prev = in_valid;
         assign x_prev = in_disc;
         assign q_prev = '0;
         assign s_prev = in_side;
      end else begin : g_next
         assign v_prev = v_ff[i-1];
         assign x_prev = x_ff[i-1];
         assign q_prev = q_ff[i-1];
         assign s_prev = s_ff[i-1];
      end

      assign trial = (DiscW'(q_prev) << (K + 1)) | (DiscW'(1) << (2 * K));

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[i] <= s_prev;
            if (x_prev >= trial) begin
               x_ff[i] <= x_prev - trial;
               q_ff[i] <= q_prev | (RootW'(1) << K);
            end else begin
               x_ff[i] <= x_prev;
               q_ff[i] <= q_prev;
            end
         end
      end
   end

   assign out_valid = v_ff[RootW-1];
   assign out_root  = q_ff[RootW-1];
   assign out_side  = s_ff[RootW-1];

   // remainder must stay below the next square step: x < 2q + 1
   assert property (@(posedge clock) disable iff (reset)
      v_ff[RootW-1] |-> (x_ff[RootW-1] <= (DiscW'(q_ff[RootW-1]) << 1)))
      else $error("root remainder out of range");

endmodule

/* rtl/cstoi_div.sv */
module cstoi_div
   import cstoi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [RootW-1:0] in_root,
   input  side_type         in_side,
   output logic             out_valid,
   output res_type          out_res
);

   // numerator stage
   logic            n_v_ff, n_hit_ff, n_late_ff;
   logic [NumW-1:0] n_ff;
   logic [AW-1:0]   n_a_ff;
   // setup stage
   logic            u_v_ff, u_hit_ff, u_late_ff, u_sat_ff;
   logic [RemW-1:0] u_r_ff;
   logic [TimeW-1:0] u_lo_ff;
   logic [AW-1:0]   u_a_ff;

   logic [NumW-1:0] n_in;
   logic            early;

   always_comb begin
      early = in_side.hle0 && in_side.cge0;
      if (early) begin
         n_in = {1'b0, in_side.hmag} - {1'b0, in_root};
      end else if (in_side.hle0) begin
         n_in = {1'b0, in_side.hmag} + {1'b0, in_root};
      end else begin
         n_in = {1'b0, in_root} - {1'b0, in_side.hmag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_v_ff <= 1'b0;
         u_v_ff <= 1'b0;
      end else if (en) begin
         n_v_ff <= in_valid;
         u_v_ff <= n_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff      <= n_in;
         n_a_ff    <= in_side.a;
         n_hit_ff  <= in_side.ok;
         n_late_ff <= !early;

         // quotient reaches 2^32 exactly when N >= a * 2^16
         u_sat_ff  <= ({{(AW+FracW-NumW){1'b0}}, n_ff} >= {n_a_ff, {FracW{1'b0}}});
         u_r_ff    <= RemW'(n_ff[NumW-1:FracW]);
         u_lo_ff   <= {n_ff[FracW-1:0], {(TimeW-FracW){1'b0}}};
         u_a_ff    <= n_a_ff;
         u_hit_ff  <= n_hit_ff;
         u_late_ff <= n_late_ff;
      end
   end

   // restoring division, one quotient bit per stage
   logic             d_v_ff    [TimeW];
   logic [RemW-1:0]  d_r_ff    [TimeW];
   logic [TimeW-1:0] d_q_ff    [TimeW];
   logic [TimeW-1:0] d_lo_ff   [TimeW];
   logic [AW-1:0]    d_a_ff    [TimeW];
   logic             d_hit_ff  [TimeW];
   logic             d_late_ff [TimeW];
   logic             d_sat_ff  [TimeW];

   for (genvar j = 0; j < TimeW; j++) begin : g_step
      localparam int B = TimeW - 1 - j;
      logic             v_prev, hit_prev, late_prev, sat_prev;
      logic [RemW-1:0]  r_prev, r_sh;
      logic [TimeW-1:0] q_prev, lo_prev;
      logic [AW-1:0]    a_prev;

      if (j == 0) begin : g_first
         assign v_prev    = u_v_ff;
         assign r_prev    = u_r_ff;
         assign q_prev    = '0;
         assign lo_prev   = u_lo_ff;
         assign a_prev    = u_a_ff;
         assign hit_prev  = u_hit_ff;
         assign late_prev = u_late_ff;
         assign sat_prev  = u_sat_ff;
      end else begin : g_next
         assign v_prev    = d_v_ff[j-1];
         assign r_prev    = d_r_ff[j-1];
         assign q_prev    = d_q_ff[j-1];
         assign lo_prev   = d_lo_ff[j-1];
         assign a_prev    = d_a_ff[j-1];
         assign hit_prev  = d_hit_ff[j-1];
         assign late_prev = d_late_ff[j-1];
         assign sat_prev  = d_sat_ff[j-1];
      end

      assign r_sh = {r_prev[RemW-2:0], lo_prev[B]};

      always_ff @(posedge clock) begin
         if (reset) begin
            d_v_ff[j] <= 1'b0;
         end else if (en) begin
            d_v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d_lo_ff[j]   <= lo_prev;
            d_a_ff[j]    <= a_prev;
            d_hit_ff[j]  <= hit_prev;
            d_late_ff[j] <= late_prev;
            d_sat_ff[j]  <= sat_prev;
            if (r_sh >= a_prev) begin
               d_r_ff[j] <= r_sh - a_prev;
               d_q_ff[j] <= q_prev | (TimeW'(1) << B);
            end else begin
               d_r_ff[j] <= r_sh;
               d_q_ff[j] <= q_prev;
            end
         end
      end
   end

   always_comb begin
      out_res.hit          = d_hit_ff[TimeW-1];
      out_res.late_root    = d_hit_ff[TimeW-1] && d_late_ff[TimeW-1];
      if (!d_hit_ff[TimeW-1]) begin
         out_res.contact_time = '0;
      end else if (d_sat_ff[TimeW-1]) begin
         out_res.contact_time = '1;
      end else begin
         out_res.contact_time = d_q_ff[TimeW-1];
      end
   end

   assign out_valid = d_v_ff[TimeW-1];

   // remainder stays below the divisor on a hit word with no saturation
   assert property (@(posedge clock) disable iff (reset)
      (d_v_ff[TimeW-1] && d_hit_ff[TimeW-1] && !d_sat_ff[TimeW-1])
      |-> (d_r_ff[TimeW-1] < d_a_ff[TimeW-1]))
      else $error("division remainder not below divisor");

endmodule

/* rtl/circle_sweep_time_of_impact.sv */
// Moving circle pair time of impact.
// req_ carries one pair of circles per word: position and velocity (signed
// Q16.16) and radius (unsigned Q15.16) of each. rsp_ returns one word per pair:
// hit, contact time (unsigned Q16.16, saturated to all ones) and late_root,
// set when the circles already overlap and the exit root was used.
// An accepted req_ word passes 7 stages that form a, h, c and the discriminant
// through split 34-bit multipliers, 67 stages that produce the square root
// one bit each, 2 stages that form the numerator and the saturation test,
// 32 stages that divide one quotient bit each, and then one output register
// that drives rsp_tvalid.
// Unless stalled, one pair is accepted per cycle. When rsp_tready is low the
// output word holds and a skid register catches the next finished word; while
// the skid register is full the whole pipeline holds and req_tready is low.
// Synchronous reset empties the pipeline and both output registers.
module circle_sweep_time_of_impact
   import cstoi_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius,
   // second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_radius
   input  logic [ReqW-1:0] req_tdata,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   // hit, contact_time, late_root
   output logic [RspW-1:0] rsp_tdata
);

   logic             en;
   pair_type         pair;
   logic             f_valid, s_valid, p_valid;
   logic [DiscW-1:0] f_disc;
   side_type         f_side, s_side;
   logic [RootW-1:0] s_root;
   res_type          p_res;

   logic             out_v_ff, skid_v_ff;
   res_type          out_ff, skid_ff;
   logic             take;

   assign en         = !skid_v_ff;
   assign req_tready = en;
   assign pair       = pair_type'(req_tdata[$bits(pair_type)-1:0]);

   cstoi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_pair   (pair),
      .out_valid (f_valid),
      .out_disc  (f_disc),
      .out_side  (f_side)
   );

   cstoi_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_disc   (f_disc),
      .in_side   (f_side),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   cstoi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_root   (s_root),
      .in_side   (s_side),
      .out_valid (p_valid),
      .out_res   (p_res)
   );

   assign take = en && p_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_v_ff && !rsp_tready) begin
         // output stalled: park the next word
         if (take) begin
            skid_v_ff <= 1'b1;
         end
      end else if (skid_v_ff) begin
         out_v_ff  <= 1'b1;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (out_v_ff && !rsp_tready) begin
         if (take) begin
            skid_ff <= p_res;
         end
      end else if (skid_v_ff) begin
         out_ff <= skid_ff;
      end else if (take) begin
         out_ff <= p_res;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {{(RspW-$bits(res_type)){1'b0}}, out_ff};

   assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid word without output word");

   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_tready))
      else $error("skid filled while output was free");

   assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !out_ff.hit) |-> (out_ff.contact_time == '0 && !out_ff.late_root))
      else $error("miss word carries a time or root flag");

endmodule

/* test/time_of_impact_checker.sv */
`timescale 1ns / 100ps

module time_of_impact_checker
   import cstoi_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   input  logic            req_tready,
   input  logic [ReqW-1:0] req_tdata,
   input  logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  logic [RspW-1:0] rsp_tdata,
   output int              failures,
   output int              pending,
   output int              hit_count,
   output int              late_count
);

   typedef logic signed [199:0] big_t;

   res_type impact_queue[$];

   function automatic res_type impact_of(input pair_type p);
      big_t px, py, vx, vy, rsum, a, h, c, disc, s, t, num, q;
      res_type r;
      r = '0;
      px = $signed(p.second_pos_x) - $signed(p.first_pos_x);
      py = $signed(p.second_pos_y) - $signed(p.first_pos_y);
      vx = $signed(p.second_vel_x) - $signed(p.first_vel_x);
      vy = $signed(p.second_vel_y) - $signed(p.first_vel_y);
      rsum = p.first_radius + p.second_radius;
      a = vx * vx + vy * vy;
      h = px * vx + py * vy;
      c = px * px + py * py - rsum * rsum;
      disc = h * h - a * c;
      if (disc < 0 || a == 0) return r;
      s = 0;
      for (int k = 69; k >= 0; k--) begin
         t = s | (big_t'(1) <<< k);
         if (t * t <= disc) s = t;
      end
      if (h <= 0 && c >= 0) begin
         num = -h - s;
      end else if (h <= 0 || c <= 0) begin
         num = s - h;
         r.late_root = 1'b1;
      end else begin
         return r;
      end
      q = (num <<< FracW) / a;
      r.hit = 1'b1;
      r.contact_time = (q > big_t'(32'hFFFF_FFFF)) ? '1 : q[TimeW-1:0];
      return r;
   endfunction

   // append the predicted word for one accepted pair
   task automatic queue_impact(input pair_type p);
      impact_queue = {impact_queue, impact_of(p)};
   endtask

   initial begin
      failures = 0;
      pending = 0;
      hit_count = 0;
      late_count = 0;
   end

   always @(posedge clock) begin
      res_type want, got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            queue_impact(pair_type'(req_tdata[$bits(pair_type)-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            got = res_type'(rsp_tdata[$bits(res_type)-1:0]);
            if (impact_queue.size() == 0) begin
               $error("result word with nothing outstanding: %h", rsp_tdata);
               failures++;
            end else begin
               want = impact_queue.pop_front();
               if (got.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, got.hit);
                  failures++;
               end
               if (got.contact_time !== want.contact_time) begin
                  $error("contact_time: expected %h, got %h",
                         want.contact_time, got.contact_time);
                  failures++;
               end
               if (got.late_root !== want.late_root) begin
                  $error("late_root: expected %0d, got %0d", want.late_root, got.late_root);
                  failures++;
               end
               if (want.hit) hit_count++;
               if (want.late_root) late_count++;
            end
         end
         pending = impact_queue.size();
      end
   end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import cstoi_pkg::*;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [ReqW-1:0] req_tdata = '0;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [RspW-1:0] rsp_tdata;
   int              failures, pending, hit_count, late_count;
   int              sent = 0;
   bit              calm = 1'b0;
   bit              hold_off = 1'b0;

   localparam int One = 65536;

   circle_sweep_time_of_impact dut (.*);

   time_of_impact_checker checker_i (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic pair_type circles(input int p1x, p1y, v1x, v1y, r1,
                                        input int p2x, p2y, v2x, v2y, r2);
      pair_type p;
      p.first_pos_x = p1x;  p.first_pos_y = p1y;
      p.first_vel_x = v1x;  p.first_vel_y = v1y;  p.first_radius = r1[30:0];
      p.second_pos_x = p2x; p.second_pos_y = p2y;
      p.second_vel_x = v2x; p.second_vel_y = v2y; p.second_radius = r2[30:0];
      return p;
   endfunction

   function automatic int near(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int p1x, p1y, p2x, p2y, sh;
      case ($urandom_range(0, 9))
         0, 1: begin
            p = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, 30'($urandom)};
         end
         2: begin
            p = circles(near(1 << 24), near(1 << 24), near(1 << 20), near(1 << 20),
                        $urandom_range(0, 1 << 22), near(1 << 24), near(1 << 24), 0, 0,
                        $urandom_range(0, 1 << 22));
            p.second_vel_x = p.first_vel_x;
            p.second_vel_y = p.first_vel_y;
         end
         3, 4, 5: begin
            p = circles(near(1 << 22), near(1 << 22), near(1 << 19), near(1 << 19),
                        $urandom_range(0, 1 << 20), near(1 << 22), near(1 << 22),
                        near(1 << 19), near(1 << 19), $urandom_range(0, 1 << 20));
         end
         default: begin
            // aim the second circle back at the first, jittered
            p1x = near(1 << 22); p1y = near(1 << 22);
            p2x = near(1 << 22); p2y = near(1 << 22);
            sh = $urandom_range(0, 5);
            p = circles(p1x, p1y, 0, 0, $urandom_range(0, 1 << 21), p2x, p2y,
                        ((p1x - p2x) >>> sh) + near(1 << 14),
                        ((p1y - p2y) >>> sh) + near(1 << 14), $urandom_range(0, 1 << 21));
         end
      endcase
      return p;
   endfunction

   task automatic send_pair(input pair_type p);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ReqW - $bits(pair_type)){1'b0}}, p};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // drop valid, then wait until every outstanding word has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         stall = calm ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid && !hold_off);
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // zero relative velocity, extremes, min/max radii
      send_pair(circles(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pair('1);
      send_pair(circles(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 31'h7FFF_FFFF));
      send_pair(circles(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0));
      // head-on approach, earlier root
      send_pair(circles(0, 0, 0, 0, One, 10 * One, 0, -One, 0, One));
      // overlap, approaching and receding: later root
      send_pair(circles(0, 0, 0, 0, 2 * One, One, 0, -One, 0, One));
      send_pair(circles(0, 0, 0, 0, 2 * One, One, 0, One, 0, One));
      // receding apart: both roots negative
      send_pair(circles(0, 0, 0, 0, One, 10 * One, 0, One, 0, One));
      // passing wide: negative discriminant
      send_pair(circles(0, 0, 0, 0, One, 10 * One, 10 * One, -One, 0, One));
      // tangent graze
      send_pair(circles(0, 0, 0, 0, One, -5 * One, 2 * One, One, 0, One));
      // tangent touching right now
      send_pair(circles(0, 0, 0, 0, One, 2 * One, 0, One, 0, One));
      // huge distance, tiny speed: saturated time
      send_pair(circles(0, 0, 0, 0, 0, 30000 * One, 0, -1, 0, 0));
      send_pair(circles(0, 0, 1, 0, 0, 32'h7FFF_0000, 0, 0, 0, 1));
      drain();
      // long receiver hold-off while the sender keeps offering
      hold_off = 1'b1;
      repeat (200) send_pair(random_pair());
      drain();
      calm = 1'b1;
      repeat (150) send_pair(random_pair());
      calm = 1'b0;
      repeat (1100) send_pair(random_pair());
      req_tvalid <= 1'b0;
      drain();
      repeat (120) @(posedge clock);
      $display("%0d circle pairs checked: %0d contacts, %0d with circles already overlapping",
               sent, hit_count, late_count);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
